// ===== hw/rtl/tgarle_pkg.sv =====
`timescale 1ns / 1ps

package tgarle_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned PIX_W     = 32;
    localparam int unsigned REP_W     = 8;
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned GATHER_W  = 24;
    localparam int unsigned PHASE_W   = 2;
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned PB_W      = 3;
    localparam int unsigned CFG_W     = 32;
    localparam int unsigned CFG_IDX_W = 2;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECODE_MODE = 2'd0,
        CFG_PIXEL_BYTES = 2'd1,
        CFG_PIXEL_TOTAL = 2'd2
    } t_cfg_index;

    // Bits of the decode mode register.
    localparam int unsigned MODE_RLE_BIT  = 0;
    localparam int unsigned MODE_GREY_BIT = 1;

    localparam logic [MODE_W-1:0] MODE_RESET = 2'd0;
    localparam logic [PB_W-1:0]   PB_RESET   = 3'd3;
    localparam logic [PB_W-1:0]   PB_RGBA    = 3'd4;

    // Last byte index within a pixel for each pixel layout.
    localparam logic [PHASE_W-1:0] LAST_IDX_GREY = 2'd0;
    localparam logic [PHASE_W-1:0] LAST_IDX_RGB  = 2'd2;
    localparam logic [PHASE_W-1:0] LAST_IDX_RGBA = 2'd3;

    // Packet header layout.
    localparam int unsigned HDR_RUN_BIT = 7;
    localparam int unsigned HDR_CNT_W   = 7;

    localparam logic [REP_W-1:0] REPEAT_ONE = 8'd1;
    localparam logic [REP_W-1:0] REPEAT_MAX = 8'd128;

endpackage

// ===== hw/rtl/tga_rle_pixel_decoder.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_data_byte, i_first_byte
// output    out        o_out_valid / i_out_ready  o_pixel_value, o_repeat_count, o_last_pixel
// config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// One byte is transferred per cycle while input ready is high. A byte sits in the
// input register, and the decode stage behind it loads the result register once that
// register is free or being emptied; a pixel result is offered from there. A result
// that is not taken holds the decode stage: the input register fills and then input
// ready drops. Reset (synchronous, active low) restores the register defaults and
// clears all decode state.

module tga_rle_pixel_decoder
    import tgarle_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // byte stream in
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [BYTE_W-1:0]    i_data_byte,
    input  logic                 i_first_byte,
    // pixel results out
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [PIX_W-1:0]     o_pixel_value,
    output logic [REP_W-1:0]     o_repeat_count,
    output logic                 o_last_pixel
);

    // Configuration registers.
    logic [MODE_W-1:0] r_decode_mode;
    logic [PB_W-1:0]   r_pixel_bytes;
    logic [CNT_W-1:0]  r_pixel_total;

    // Input register.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_first;

    // Decode state.
    logic [PHASE_W-1:0]  r_byte_phase,   n_byte_phase;
    logic [GATHER_W-1:0] r_pixel_gather, n_pixel_gather;
    logic [REP_W-1:0]    r_packet_left,  n_packet_left;
    logic                r_run_packet,   n_run_packet;
    logic [CNT_W-1:0]    r_pixels_done,  n_pixels_done;

    // Result register.
    logic              r_out_valid,   n_out_valid;
    logic [PIX_W-1:0]  r_pixel_value, n_pixel_value;
    logic [REP_W-1:0]  r_repeat,      n_repeat;
    logic              r_last,        n_last;

    // The decode stage moves forward whenever the result register is free or
    // is being emptied in this same cycle.
    logic advance;
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Decode working signals.
    logic                 grey_mode;
    logic                 rle_mode;
    logic [PHASE_W-1:0]   e_phase;
    logic [GATHER_W-1:0]  e_gather;
    logic [REP_W-1:0]     e_left;
    logic                 e_run;
    logic [CNT_W-1:0]     e_done;
    logic [CNT_W:0]       remain_full;
    logic [CNT_W-1:0]     remain;
    logic                 image_done;
    logic                 remain_small;
    logic [PHASE_W-1:0]   last_idx;
    logic [REP_W-1:0]     want_repeat;
    logic [REP_W-1:0]     clip_repeat;

    always_comb begin
        grey_mode = r_decode_mode[MODE_GREY_BIT];
        rle_mode  = r_decode_mode[MODE_RLE_BIT];

        // A first byte restarts the decoder before the byte itself is used.
        e_phase  = r_in_first ? '0 : r_byte_phase;
        e_gather = r_in_first ? '0 : r_pixel_gather;
        e_left   = r_in_first ? '0 : r_packet_left;
        e_run    = r_in_first ? 1'b0 : r_run_packet;
        e_done   = r_in_first ? '0 : r_pixels_done;

        // Pixels still owed to the image; a borrow means the total was
        // lowered below what has already been sent.
        remain_full  = {1'b0, r_pixel_total} - {1'b0, e_done};
        remain       = remain_full[CNT_W-1:0];
        image_done   = remain_full[CNT_W] || (remain == '0);
        remain_small = (remain[CNT_W-1:REP_W] == '0);

        if (grey_mode) begin
            last_idx = LAST_IDX_GREY;
        end else if (r_pixel_bytes == PB_RGBA) begin
            last_idx = LAST_IDX_RGBA;
        end else begin
            last_idx = LAST_IDX_RGB;
        end

        // Repeat count before clipping: whole packet count for a run.
        if (rle_mode && e_run) begin
            want_repeat = e_left;
        end else begin
            want_repeat = REPEAT_ONE;
        end
        if (remain_small && (remain[REP_W-1:0] < want_repeat)) begin
            clip_repeat = remain[REP_W-1:0];
        end else begin
            clip_repeat = want_repeat;
        end

        n_byte_phase   = e_phase;
        n_pixel_gather = e_gather;
        n_packet_left  = e_left;
        n_run_packet   = e_run;
        n_pixels_done  = e_done;
        n_out_valid    = 1'b0;
        n_pixel_value  = '0;
        n_repeat       = clip_repeat;
        n_last         = remain_small && (remain[REP_W-1:0] == clip_repeat);

        if (image_done) begin
            // Bytes beyond the last pixel are dropped.
        end else if (rle_mode && (e_left == '0)) begin
            // Packet header: count in the low bits, run flag on top.
            n_packet_left  = {1'b0, r_in_byte[HDR_CNT_W-1:0]} + REPEAT_ONE;
            n_run_packet   = r_in_byte[HDR_RUN_BIT];
            n_byte_phase   = '0;
            n_pixel_gather = '0;
        end else if (e_phase < last_idx) begin
            case (e_phase)
                2'd0:    n_pixel_gather[7:0]   = r_in_byte;
                2'd1:    n_pixel_gather[15:8]  = r_in_byte;
                2'd2:    n_pixel_gather[23:16] = r_in_byte;
                default: n_pixel_gather        = e_gather;
            endcase
            n_byte_phase = e_phase + 2'd1;
        end else begin
            // Last byte of the pixel: stored order is blue, green, red(, alpha),
            // sent out as red, green, blue, alpha.
            if (grey_mode) begin
                n_pixel_value = {24'd0, r_in_byte};
            end else if (last_idx == LAST_IDX_RGBA) begin
                n_pixel_value = {r_in_byte, e_gather[7:0], e_gather[15:8],
                                 e_gather[23:16]};
            end else begin
                n_pixel_value = {8'd0, e_gather[7:0], e_gather[15:8], r_in_byte};
            end
            n_byte_phase   = '0;
            n_pixel_gather = '0;
            if (rle_mode) begin
                if (e_run) begin
                    n_packet_left = '0;
                end else begin
                    n_packet_left = e_left - REPEAT_ONE;
                end
            end
            n_pixels_done = e_done + {{(CNT_W-REP_W){1'b0}}, clip_repeat};
            n_out_valid   = 1'b1;
        end
    end

    // Configuration registers take writes directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode <= MODE_RESET;
            r_pixel_bytes <= PB_RESET;
            r_pixel_total <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DECODE_MODE: r_decode_mode <= i_cfg_data[MODE_W-1:0];
                CFG_PIXEL_BYTES: r_pixel_bytes <= i_cfg_data[PB_W-1:0];
                CFG_PIXEL_TOTAL: r_pixel_total <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: loads on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte  <= i_data_byte;
            r_in_first <= i_first_byte;
        end
    end

    // Decode state moves once per decoded byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_phase   <= '0;
            r_pixel_gather <= '0;
            r_packet_left  <= '0;
            r_run_packet   <= 1'b0;
            r_pixels_done  <= '0;
        end else if (advance) begin
            r_byte_phase   <= n_byte_phase;
            r_pixel_gather <= n_pixel_gather;
            r_packet_left  <= n_packet_left;
            r_run_packet   <= n_run_packet;
            r_pixels_done  <= n_pixels_done;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_out_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_out_valid) begin
            r_pixel_value <= n_pixel_value;
            r_repeat      <= n_repeat;
            r_last        <= n_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_value  = r_pixel_value;
    assign o_repeat_count = r_repeat;
    assign o_last_pixel   = r_last;

endmodule

// ===== hw/rtl/tgarle_checker.sv =====
`timescale 1ns / 1ps

module tgarle_checker
    import tgarle_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [PIX_W-1:0]     o_pixel_value,
    input logic [REP_W-1:0]     o_repeat_count,
    input logic                 o_last_pixel
);

    // A stalled result keeps its value until transferred.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel_value)
            && $stable(o_repeat_count) && $stable(o_last_pixel))
        else $error("result changed while stalled");

    // With the result register empty the input side is never held off.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with no pending result");

    // Every result covers between one and a full packet of pixels.
    a_repeat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_repeat_count != '0) && (o_repeat_count <= REPEAT_MAX))
        else $error("repeat count out of range");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

endmodule

bind tga_rle_pixel_decoder tgarle_checker u_tgarle_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_pixel_value  (o_pixel_value),
    .o_repeat_count (o_repeat_count),
    .o_last_pixel   (o_last_pixel)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

import tgarle_pkg::*;

// Decode modes as the decode mode register encodes them.
typedef enum logic [MODE_W-1:0] {
    DEC_RAW_COLOR = 2'd0,
    DEC_RLE_COLOR = 2'd1,
    DEC_RAW_GRAY  = 2'd2,
    DEC_RLE_GRAY  = 2'd3
} t_decode_mode;

typedef struct {
    logic [PIX_W-1:0] value;
    logic [REP_W-1:0] count;
    logic             last;
} t_pixel_result;

// Keeps a private copy of the decoder registers and state, works out the pixel
// each transferred byte finishes, and checks the pixel results in order.
class tga_pixel_board;
    t_decode_mode        mode;
    logic [PB_W-1:0]     pix_bytes;
    logic [CNT_W-1:0]    total;
    logic [PHASE_W-1:0]  phase;
    logic [GATHER_W-1:0] gather;
    logic [REP_W-1:0]    left;
    logic                in_run;
    logic [CNT_W-1:0]    done;
    t_pixel_result       pixels_due[$];
    int errors, n_bytes, n_headers, n_dropped, n_results, n_clipped, n_images;

    function new();
        mode      = t_decode_mode'(MODE_RESET);
        pix_bytes = PB_RESET;
        total     = '0;
        restart_image();
    endfunction

    function void restart_image();
        phase  = '0;
        gather = '0;
        left   = '0;
        in_run = 1'b0;
        done   = '0;
    endfunction

    function void write_register(t_cfg_index idx, logic [CFG_W-1:0] d);
        case (idx)
            CFG_DECODE_MODE: mode = t_decode_mode'(d[MODE_W-1:0]);
            CFG_PIXEL_BYTES: pix_bytes = d[PB_W-1:0];
            CFG_PIXEL_TOTAL: total = d[CNT_W-1:0];
            default: ;
        endcase
    endfunction

    function int unsigned pending();
        return pixels_due.size();
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b, logic restart);
        t_pixel_result    r;
        int unsigned      len;
        logic [CNT_W-1:0] remaining;
        logic [CNT_W-1:0] rep;
        n_bytes++;
        if (restart) restart_image();
        if (done >= total) begin
            n_dropped++;
            return;
        end
        if (mode[MODE_RLE_BIT] && left == '0) begin
            left   = REP_W'(b[HDR_CNT_W-1:0]) + 1'b1;
            in_run = b[HDR_RUN_BIT];
            phase  = '0;
            gather = '0;
            n_headers++;
            return;
        end
        len = mode[MODE_GREY_BIT] ? 1 : (pix_bytes == PB_RGBA ? 4 : 3);
        if (int'(phase) + 1 < len) begin
            gather = gather | (GATHER_W'(b) << (8 * phase));
            phase  = phase + 1'b1;
            return;
        end
        if (mode[MODE_GREY_BIT])
            r.value = {24'h000000, b};
        else if (len == 4)
            r.value = {b, gather[7:0], gather[15:8], gather[23:16]};
        else
            r.value = {8'h00, gather[7:0], gather[15:8], b};
        phase  = '0;
        gather = '0;
        remaining = total - done;
        rep = 1;
        if (mode[MODE_RLE_BIT]) begin
            if (in_run) begin
                rep  = CNT_W'(left);
                left = '0;
            end else begin
                left = left - 1'b1;
            end
        end
        if (rep > remaining) begin
            rep = remaining;
            n_clipped++;
        end
        done    = done + rep;
        r.count = rep[REP_W-1:0];
        r.last  = (done == total);
        pixels_due.push_back(r);
        n_results++;
        if (r.last) n_images++;
    endfunction

    task report(string what);
        errors++;
        if (errors <= 40) $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    task check_pixel(logic [PIX_W-1:0] value, logic [REP_W-1:0] count, logic last);
        t_pixel_result want;
        if (pixels_due.size() == 0) begin
            report($sformatf("pixel %h x%0d last %b with no pixel due", value, count, last));
            return;
        end
        want = pixels_due.pop_front();
        if (value !== want.value)
            report($sformatf("pixel value %h, want %h", value, want.value));
        if (count !== want.count)
            report($sformatf("repeat count %0d, want %0d", count, want.count));
        if (last !== want.last)
            report($sformatf("last pixel flag %b, want %b", last, want.last));
    endtask
endclass

module tb;

    // Wait, with margin, for a byte the decoder may still hold after the last pixel
    // result has come out, in the input register or the decode stage.
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 16;
    localparam int PHASE_ITEMS   = 98;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    t_cfg_index           cfg_index = CFG_DECODE_MODE;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [BYTE_W-1:0]    data_byte = '0;
    logic                 first_byte = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [PIX_W-1:0]     pixel_value;
    logic [REP_W-1:0]     repeat_count;
    logic                 last_pixel;

    tga_pixel_board sb;

    // Chance in percent that the sender idles or the receiver stalls in a cycle.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // Cycles for which the receiver refuses every result, counted down below.
    int holdoff_left   = 0;
    int n_settings     = 0;
    bit drained_once   = 1'b0;

    tga_rle_pixel_decoder u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_data_byte    (data_byte),
        .i_first_byte   (first_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_pixel_value  (pixel_value),
        .o_repeat_count (repeat_count),
        .o_last_pixel   (last_pixel)
    );

    always #10 clk = ~clk;

    // The receiver decides at each falling edge whether it takes a result at
    // the next rising edge. A pending hold-off overrides the random stalls.
    always @(negedge clk) begin
        if (holdoff_left > 0) begin
            holdoff_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Every result transfer is checked against the oldest pixel still due.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_pixel(pixel_value, repeat_count, last_pixel);
    end

    // Offers one byte, idling first at random, and returns once the byte has
    // been transferred. Valid stays high from one byte to the next when there
    // is no idle cycle between them.
    task automatic send_byte(input logic [BYTE_W-1:0] d, input logic f);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= d;
        first_byte <= f;
        forever begin
            @(posedge clk);
            if (in_ready) break;
        end
        sb.take_byte(d, f);
    endtask

    // The four stored bytes of an RGBA pixel, blue first.
    task automatic send_rgba(input logic [31:0] stored);
        send_byte(stored[31:24], 1'b0);
        send_byte(stored[23:16], 1'b0);
        send_byte(stored[15:8], 1'b0);
        send_byte(stored[7:0], 1'b0);
    endtask

    // A byte now and then restarts the decoder in the middle of a packet.
    function automatic bit stray_restart();
        return $urandom_range(0, 59) == 0;
    endfunction

    // Stops offering bytes and waits until every predicted pixel has come out.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Drains, then gives a byte that finishes no pixel time to leave the pipeline,
    // so that the registers can be written safely.
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input t_decode_mode mode, input logic [PB_W-1:0] pb,
                                input logic [CNT_W-1:0] total);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DECODE_MODE;
        cfg_data  <= CFG_W'(mode);
        @(negedge clk);
        cfg_index <= CFG_PIXEL_BYTES;
        cfg_data  <= CFG_W'(pb);
        @(negedge clk);
        cfg_index <= CFG_PIXEL_TOTAL;
        cfg_data  <= CFG_W'(total);
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_register(CFG_DECODE_MODE, CFG_W'(mode));
        sb.write_register(CFG_PIXEL_BYTES, CFG_W'(pb));
        sb.write_register(CFG_PIXEL_TOTAL, CFG_W'(total));
        n_settings++;
    endtask

    // One phase of random stimulus under one register setting. Most bytes form
    // well-built images: packet headers followed by the pixels they announce.
    // Some images are cut short, some bytes trail an image, and a few restarts
    // land in the middle of a packet. Phases that do not open with a restart
    // carry the decode state over the register change.
    task automatic run_phase(input int ph, input int n_items);
        t_decode_mode     mode;
        logic [PB_W-1:0]  pb;
        logic [CNT_W-1:0] total;
        int               sent, target, pix, cnt, npx, len;
        bit               rle, run, fb;
        mode = t_decode_mode'((ph + ph / 4) % 4);
        case (ph)
            1: pb = '0;
            2: pb = '1;
            default: begin
                case ($urandom_range(0, 3))
                    0: pb = PB_RESET;
                    1: pb = PB_RGBA;
                    default: pb = PB_W'($urandom_range(0, 7));
                endcase
            end
        endcase
        case (ph)
            5: total = '0;
            9: total = '1;
            13: total = $urandom();
            default: total = $urandom_range(1, 60);
        endcase
        write_config(mode, pb, total);
        rle = mode[MODE_RLE_BIT];
        len = mode[MODE_GREY_BIT] ? 1 : (pb == PB_RGBA ? 4 : 3);

        case (ph % 4)
            0: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct  = 76;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct = 76;
            end
            default: begin
                send_idle_pct  = 20;
                recv_stall_pct = 20;
            end
        endcase

        // The receiver shuts off for a long stretch while the sender keeps
        // offering bytes, so the decoder fills up and drops its input ready.
        if (ph == 4) begin
            @(posedge clk);
            holdoff_left = 300;
        end

        sent = 0;
        fb = (ph % 3 != 0);
        while (sent < n_items) begin
            target = (total > 150) ? $urandom_range(10, 150) : int'(total);
            pix = 0;
            while (pix < target && sent < n_items) begin
                if (rle) begin
                    cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128)
                                                      : $urandom_range(1, 4);
                    run = $urandom_range(0, 1);
                    send_byte({run, 7'(cnt - 1)}, fb);
                    fb = 1'b0;
                    sent++;
                    npx = run ? 1 : cnt;
                end else begin
                    cnt = 1;
                    npx = 1;
                end
                repeat (npx * len) begin
                    send_byte(BYTE_W'($urandom_range(0, 255)), fb | stray_restart());
                    fb = 1'b0;
                    sent++;
                end
                pix += cnt;
                if ($urandom_range(0, 39) == 0) break;
            end
            // Trailing bytes follow; past the end of a completed image they should be dropped.
            repeat ($urandom_range(target == 0 ? 1 : 0, 3)) begin
                send_byte(BYTE_W'($urandom_range(0, 255)), fb);
                fb = 1'b0;
                sent++;
            end
            fb = 1'b1;
            // Once, the sender pauses in mid phase until all pixels are out.
            if (ph == 8 && !drained_once && sent >= n_items / 2) begin
                drain();
                drained_once = 1'b1;
            end
        end
        settle();
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // With the reset registers the pixel total is zero, so these bytes must
        // produce nothing.
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        settle();

        // Directed image of 200 RGBA pixels in RLE: a full run of 128, a raw
        // packet of one pixel, and a second full run that must be clipped to the
        // 71 pixels left and close the image. A byte after the end is dropped,
        // then a restart opens a new image with a run of one.
        write_config(DEC_RLE_COLOR, PB_RGBA, 32'd200);
        send_byte(8'hFF, 1'b1);
        send_rgba(32'h00FF0FF0);
        send_byte(8'h00, 1'b0);
        send_rgba(32'hFF00F00F);
        send_byte(8'hFF, 1'b0);
        send_rgba(32'h12345678);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h80, 1'b1);
        send_rgba(32'hFFFFFFFF);
        settle();

        for (int ph = 0; ph < PHASES; ph++)
            run_phase(ph, PHASE_ITEMS);

        $display("Run covered %0d byte transfers over %0d register settings, %0d headers, %0d dropped.",
                 sb.n_bytes, n_settings, sb.n_headers, sb.n_dropped);
        $display("It checked %0d pixel results, %0d runs clipped, %0d images completed.",
                 sb.n_results, sb.n_clipped, sb.n_images);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Guard against a hung handshake: far beyond the slowest legal run.
    initial begin
        #4_000_000;
        $display("Timeout: the byte stream or the pixel results stopped moving.");
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== tga_rle_pixel_decoder.f =====
hw/rtl/tgarle_pkg.sv
hw/rtl/tga_rle_pixel_decoder.sv
hw/rtl/tgarle_checker.sv
tb/tb.sv
